// ----- rtl/core/hpe_pkg.sv -----
// Shared types, constants and helpers for the request-line path extractor.
// Used by every file under rtl/core; no dependencies.
package hpe_pkg;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // results produced by one input byte, at most
   localparam int unsigned MAX_RES = 3;

   typedef enum logic [2:0] {
      PH_METHOD = 3'd0,
      PH_PATH   = 3'd1,
      PH_PCT1   = 3'd2,
      PH_PCT2   = 3'd3,
      PH_QUERY  = 3'd4,
      PH_CLOSED = 3'd5,
      PH_FAILED = 3'd6
   } hpe_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } hpe_req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       out_run_end;
   } hpe_rsp_type;

   // results of one byte, handed from the decoder to the result queue
   typedef struct packed {
      logic [1:0]                cnt;
      hpe_rsp_type [MAX_RES-1:0] item;
   } hpe_push_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39)      v = c - 8'h30;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
      else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
      return v[3:0];
   endfunction

endpackage

// ----- rtl/core/hpe_step.sv -----
// Per-byte decoder: phase and held-digit registers plus the decode logic
// that turns one accepted byte into up to three results. Depends on hpe_pkg.
module hpe_step import hpe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  hpe_req_type  req,
   output hpe_push_type push
);

   hpe_phase_type phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;

   logic [7:0]    c;
   logic          last;

   // effect of an ordinary path byte
   logic          pb_push;
   hpe_rsp_type   pb_res;
   hpe_phase_type pb_phase;

   hpe_rsp_type   res [MAX_RES];
   logic [1:0]    n;

   assign c    = req.in_byte;
   assign last = req.in_last;

   always_comb begin
      pb_push  = 1'b1;
      pb_res   = '{out_kind: KIND_BYTE, out_byte: c, out_run_end: 1'b0};
      pb_phase = PH_PATH;
      if (c == CH_SPACE) begin
         pb_res   = '{out_kind: KIND_OK, out_byte: 8'h00, out_run_end: 1'b0};
         pb_phase = PH_CLOSED;
      end else if (c == CH_QUEST) begin
         pb_push  = 1'b0;
         pb_phase = PH_QUERY;
      end else if (c == CH_PCT) begin
         pb_push  = 1'b0;
         pb_phase = PH_PCT1;
      end else if (c == CH_PLUS) begin
         pb_res.out_byte = CH_SPACE;
      end
   end

   always_comb begin
      res      = '{default: '0};
      n        = 2'd0;
      phase_in = phase_ff;
      held_in  = held_ff;
      if (phase_ff <= PH_QUERY && c == CH_NUL) begin
         res[0]   = '{out_kind: KIND_ERR, out_byte: 8'h00, out_run_end: 1'b0};
         n        = 2'd1;
         phase_in = PH_FAILED;
      end else begin
         unique case (phase_ff)
            PH_METHOD: begin
               if (c == CH_SPACE) phase_in = PH_PATH;
            end
            PH_PATH: begin
               res[0]   = pb_res;
               n        = {1'b0, pb_push};
               phase_in = pb_phase;
            end
            PH_PCT1: begin
               if (is_hex(c)) begin
                  held_in  = c;
                  phase_in = PH_PCT2;
               end else begin
                  // lone percent goes out literally
                  res[0]   = '{out_kind: KIND_BYTE, out_byte: CH_PCT, out_run_end: 1'b0};
                  res[1]   = pb_res;
                  n        = pb_push ? 2'd2 : 2'd1;
                  phase_in = pb_phase;
               end
            end
            PH_PCT2: begin
               held_in = 8'h00;
               if (is_hex(c)) begin
                  res[0]   = '{out_kind: KIND_BYTE,
                               out_byte: {hex_val(held_ff), hex_val(c)},
                               out_run_end: 1'b0};
                  n        = 2'd1;
                  phase_in = PH_PATH;
               end else begin
                  res[0]   = '{out_kind: KIND_BYTE, out_byte: CH_PCT, out_run_end: 1'b0};
                  res[1]   = '{out_kind: KIND_BYTE, out_byte: held_ff, out_run_end: 1'b0};
                  res[2]   = pb_res;
                  n        = pb_push ? 2'd3 : 2'd2;
                  phase_in = pb_phase;
               end
            end
            PH_QUERY: begin
               if (c == CH_SPACE) begin
                  res[0]   = '{out_kind: KIND_OK, out_byte: 8'h00, out_run_end: 1'b0};
                  n        = 2'd1;
                  phase_in = PH_CLOSED;
               end
            end
            default: ;
         endcase
      end

      if (last) begin
         // request ends with the path still open: error marker only
         if (phase_in <= PH_QUERY) begin
            res    = '{default: '0};
            res[0] = '{out_kind: KIND_ERR, out_byte: 8'h00, out_run_end: 1'b0};
            n      = 2'd1;
         end
         phase_in = PH_METHOD;
         held_in  = 8'h00;
      end

      if (n != 2'd0) res[n - 2'd1].out_run_end = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_METHOD;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      push.cnt = accept ? n : 2'd0;
      for (int i = 0; i < MAX_RES; i++) begin
         push.item[i] = res[i];
      end
   end

endmodule

// ----- rtl/core/hpe_rsp_fifo.sv -----
// Result queue: takes up to three results per cycle, returns one per cycle unless stalled.
// Flop storage with a single read port. Depends on hpe_pkg.
module hpe_rsp_fifo import hpe_pkg::*; #(
   parameter int unsigned DEPTH = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  hpe_push_type push,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output hpe_rsp_type  rsp_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   hpe_rsp_type   mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;
   logic [AW-1:0] wr_idx [MAX_RES];

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [1:0] d);
      logic [AW+1:0] s;
      s = {2'b00, p} + {{AW{1'b0}}, d};
      if (s >= (AW+2)'(DEPTH)) s = s - (AW+2)'(DEPTH);
      return s[AW-1:0];
   endfunction

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign room      = (count_ff <= CW'(DEPTH - MAX_RES));

   always_comb begin
      for (int i = 0; i < MAX_RES; i++) begin
         wr_idx[i] = wrap_add(wr_ptr_ff, 2'(i));
      end
      wr_ptr_in = wrap_add(wr_ptr_ff, push.cnt);
      rd_ptr_in = pop ? wrap_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.cnt) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (2'(i) < push.cnt) mem_ff[wr_idx[i]] <= push.item[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/http_path_extract_url_decode.sv -----
// Top level of the request-line path extractor with percent decoding.
// Instantiates hpe_step and hpe_rsp_fifo; types from hpe_pkg.
//
//   channel | ports               | payload
//   --------+---------------------+------------------------------------
//   in      | req_valid/req_stall | req_data: in_byte, in_last
//   out     | rsp_valid/rsp_stall | rsp_data: out_kind, out_byte, out_run_end
//
// One byte is accepted per cycle; its 0..3 results are written into the
// result queue in the same cycle and leave it one per cycle unless stalled, the first
// one visible the cycle after acceptance at best. The queue sets
// throughput: req_stall rises while fewer than three free slots remain. Reset
// (synchronous) empties the queue and returns the decoder to PH_METHOD.
module http_path_extract_url_decode import hpe_pkg::*; #(
   parameter int unsigned FIFO_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hpe_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hpe_rsp_type rsp_data
);

   logic         accept;
   logic         room;
   hpe_push_type push;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   hpe_step u_step (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push)
   );

   hpe_rsp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/hpe_checker.sv -----
// Port-level checks for http_path_extract_url_decode, attached by bind.
// Depends on hpe_pkg.
module hpe_port_checks import hpe_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input hpe_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input hpe_rsp_type rsp_data
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // stalled input transaction holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("input changed while stalled");

   // queue empty and open right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not empty after reset");

   // no result appears without an input transaction feeding it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("result without input");

   // end markers close their run and carry a zero byte
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind != KIND_BYTE |->
         rsp_data.out_run_end && rsp_data.out_byte == 8'h00)
      else $error("bad end marker");

endmodule

bind http_path_extract_url_decode hpe_port_checks u_hpe_port_checks (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- tb/hpe_checker.sv -----
// Scoreboard for the request-line path extractor: predicts the decoded results
// of every accepted byte and compares them with the result channel. Types from hpe_pkg.
`timescale 1ns / 100ps
module hpe_checker import hpe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  hpe_req_type       req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  hpe_rsp_type       rsp_data,
   output int unsigned       mismatch_cnt,
   output int unsigned       outstanding
);

   hpe_phase_type url_phase;
   logic [7:0]    url_held;
   hpe_rsp_type   step_q[$];
   hpe_rsp_type   decoded_q[$];

   function automatic logic hex_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   // low nibble of the ASCII code gives the digit directly, letters are offset by 9
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      if (c <= "9") return c[3:0];
      return c[3:0] + 4'd9;
   endfunction

   task automatic emit(input logic [1:0] kind, input logic [7:0] b);
      hpe_rsp_type r;
      r.out_kind    = kind;
      r.out_byte    = b;
      r.out_run_end = 1'b0;
      step_q.push_back(r);
   endtask

   // nonzero byte handled as a plain path byte, also after a broken escape
   task automatic path_char(input logic [7:0] c);
      case (c)
         CH_SPACE: begin
            emit(KIND_OK, 8'h00);
            url_phase = PH_CLOSED;
         end
         CH_QUEST: url_phase = PH_QUERY;
         CH_PCT:   url_phase = PH_PCT1;
         CH_PLUS: begin
            emit(KIND_BYTE, CH_SPACE);
            url_phase = PH_PATH;
         end
         default: begin
            emit(KIND_BYTE, c);
            url_phase = PH_PATH;
         end
      endcase
   endtask

   task automatic decode_byte(input hpe_req_type t);
      logic [7:0] c;
      c = t.in_byte;
      step_q.delete();
      if (url_phase <= PH_QUERY && c == CH_NUL) begin
         emit(KIND_ERR, 8'h00);
         url_phase = PH_FAILED;
      end else begin
         case (url_phase)
            PH_METHOD: if (c == CH_SPACE) url_phase = PH_PATH;
            PH_PATH:   path_char(c);
            PH_PCT1: begin
               if (hex_char(c)) begin
                  url_held  = c;
                  url_phase = PH_PCT2;
               end else begin
                  emit(KIND_BYTE, CH_PCT);
                  path_char(c);
               end
            end
            PH_PCT2: begin
               if (hex_char(c)) begin
                  emit(KIND_BYTE, {hex_nibble(url_held), hex_nibble(c)});
                  url_phase = PH_PATH;
               end else begin
                  emit(KIND_BYTE, CH_PCT);
                  emit(KIND_BYTE, url_held);
                  path_char(c);
               end
               url_held = 8'h00;
            end
            PH_QUERY: begin
               if (c == CH_SPACE) begin
                  emit(KIND_OK, 8'h00);
                  url_phase = PH_CLOSED;
               end
            end
            default: ;
         endcase
      end
      // a request ending with its path still open yields only the error marker
      if (t.in_last) begin
         if (url_phase <= PH_QUERY) begin
            step_q.delete();
            emit(KIND_ERR, 8'h00);
         end
         url_phase = PH_METHOD;
         url_held  = 8'h00;
      end
      if (step_q.size() != 0) step_q[step_q.size() - 1].out_run_end = 1'b1;
      foreach (step_q[k]) decoded_q.push_back(step_q[k]);
   endtask

   task automatic flag_field(input string name, input logic [7:0] want, input logic [7:0] got);
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
   endtask

   always @(posedge clock) begin : watch
      hpe_rsp_type want;
      if (reset) begin
         url_phase    = PH_METHOD;
         url_held     = 8'h00;
         mismatch_cnt = 0;
         decoded_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               mismatch_cnt++;
               $display("%0t: unexpected transaction, expected none, got %h", $time, rsp_data);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_data.out_kind !== want.out_kind)
                  flag_field("out_kind", 8'(want.out_kind), 8'(rsp_data.out_kind));
               if (rsp_data.out_byte !== want.out_byte)
                  flag_field("out_byte", want.out_byte, rsp_data.out_byte);
               if (rsp_data.out_run_end !== want.out_run_end)
                  flag_field("out_run_end", 8'(want.out_run_end), 8'(rsp_data.out_run_end));
            end
         end
         if (req_valid && !req_stall) decode_byte(req_data);
      end
      outstanding = decoded_q.size();
   end

endmodule

// ----- tb/tb_http_path_extract_url_decode.sv -----
// Testbench top for http_path_extract_url_decode: builds request-line byte
// streams, drives both channels with random idling, gives the verdict. Uses hpe_checker, hpe_pkg.
`timescale 1ns / 100ps
module tb_http_path_extract_url_decode import hpe_pkg::*;;

   localparam int unsigned NUM_ITEMS    = 180;
   localparam int unsigned HOLD_AT      = 60;
   localparam int unsigned HOLD_CYCLES  = 40;
   localparam int unsigned PAUSE_AT     = 120;
   localparam int unsigned CALM_LO      = 140;
   localparam int unsigned CALM_HI      = 185;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   hpe_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   hpe_rsp_type rsp_data;

   int unsigned mismatch_cnt;
   int unsigned outstanding;
   int unsigned sent_cnt = 0;

   logic [7:0]  line_q[$];
   hpe_req_type stim_q[$];

   always #5 clock = ~clock;

   http_path_extract_url_decode dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   hpe_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .mismatch_cnt (mismatch_cnt),
      .outstanding  (outstanding)
   );

   task automatic put(input string s);
      for (int k = 0; k < s.len(); k++) line_q.push_back(s[k]);
   endtask

   // flag the final byte of the line and move it to the stimulus list
   task automatic end_request();
      hpe_req_type t;
      foreach (line_q[k]) begin
         t.in_byte = line_q[k];
         t.in_last = (k == line_q.size() - 1);
         stim_q.push_back(t);
      end
      line_q.delete();
   endtask

   function automatic logic [7:0] rand_hex();
      int unsigned v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      case ($urandom_range(0, 5))
         0, 1:    return 8'("g" + $urandom_range(0, 19));
         2:       return 8'("G" + $urandom_range(0, 19));
         3:       return CH_PCT;
         4:       return CH_QUEST;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] rand_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == CH_SPACE || c == CH_QUEST);
      return c;
   endfunction

   task automatic path_token();
      case ($urandom_range(0, 5))
         0, 1: line_q.push_back(rand_plain());
         2:    line_q.push_back(CH_PLUS);
         3: begin
            line_q.push_back(CH_PCT);
            line_q.push_back(rand_hex());
            line_q.push_back(rand_hex());
         end
         4: begin
            line_q.push_back(CH_PCT);
            line_q.push_back(rand_non_hex());
         end
         default: begin
            line_q.push_back(CH_PCT);
            line_q.push_back(rand_hex());
            line_q.push_back(rand_non_hex());
         end
      endcase
   endtask

   task automatic random_request();
      int unsigned k;
      if ($urandom_range(0, 99) < 80) begin
         repeat ($urandom_range(1, 5)) line_q.push_back(8'("A" + $urandom_range(0, 25)));
         line_q.push_back(CH_SPACE);
         repeat ($urandom_range(0, 6)) path_token();
         if ($urandom_range(0, 3) == 0) begin
            line_q.push_back(CH_QUEST);
            repeat ($urandom_range(0, 4)) line_q.push_back(rand_plain());
         end
         k = $urandom_range(0, 99);
         if (k < 8)
            line_q.push_back(CH_NUL);
         else if (k >= 16)
            line_q.push_back(CH_SPACE);
         // bytes past the close, zero included, must be dropped
         repeat ($urandom_range(0, 2)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8))
            line_q.push_back($urandom_range(0, 3) == 0 ? CH_SPACE : 8'($urandom_range(0, 255)));
      end
      end_request();
   endtask

   initial begin : timeout
      #1000000;
      $display("Some tests failed");
      $finish;
   end

   // result side: random stalls, one long hold-off, one calm window
   initial begin : rsp_side
      bit held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sent_cnt >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (sent_cnt >= CALM_LO && sent_cnt < CALM_HI) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 18);
         end
      end
   end

   initial begin : req_side
      int unsigned i;
      bit          drained;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      drained   = 1'b0;

      // method skip, both hex cases, plus, decoded zero, zero after close
      put("G /%4f+%00%FF ");
      line_q.push_back(CH_NUL);
      end_request();
      // malformed percent, percent cut short by query, last byte before close
      put(" %g%A?");
      line_q.push_back(8'hFF);
      end_request();
      // percent and one digit cut short by the closing space
      put(" %B ");
      end_request();
      // zero byte in the method, later bytes ignored until the last
      put("x");
      line_q.push_back(CH_NUL);
      put("y");
      end_request();
      while (stim_q.size() < NUM_ITEMS) random_request();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      i = 0;
      while (i < stim_q.size()) begin
         if (i == PAUSE_AT && !drained) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
            drained = 1'b1;
         end else if ((i < CALM_LO || i >= CALM_HI) && $urandom_range(0, 99) < 18) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end else begin
            req_valid <= 1'b1;
            req_data  <= stim_q[i];
            @(posedge clock);
            while (req_stall) @(posedge clock);
            i++;
            sent_cnt = i;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_cnt == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/hpe_pkg.sv
rtl/core/hpe_step.sv
rtl/core/hpe_rsp_fifo.sv
rtl/core/http_path_extract_url_decode.sv
rtl/core/hpe_checker.sv
tb/hpe_checker.sv
tb/tb_http_path_extract_url_decode.sv
